[src/plst_pkg.sv]
// Package for the positional list store: field widths, command and status codes,
// microcode types and the control store contents.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package plst_pkg;

  // Default capacity of the element memory.
  localparam int DEPTH_DEF = 64;

  // Field widths of the request and response transfers.
  localparam int CMD_W    = 2;
  localparam int POS_W    = 7;
  localparam int NUM_W    = 7;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 7;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // Microprogram step addresses.
  localparam int STEP_W = 5;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t S_IDLE      = 5'd0;
  localparam step_t S_DISPATCH  = 5'd1;
  localparam step_t S_JT        = 5'd2;
  localparam step_t S_JT_INS    = 5'd3;
  localparam step_t S_JT_DEL    = 5'd4;
  localparam step_t S_JT_RD     = 5'd5;
  localparam step_t S_APP       = 5'd6;
  localparam step_t S_APP_WR    = 5'd7;
  localparam step_t S_INS       = 5'd8;
  localparam step_t S_INS_FULL  = 5'd9;
  localparam step_t S_INS_INIT  = 5'd10;
  localparam step_t S_MV_PRIME  = 5'd11;
  localparam step_t S_MV_LOOP   = 5'd12;
  localparam step_t S_MV_END    = 5'd13;
  localparam step_t S_DEL_FIN   = 5'd14;
  localparam step_t S_INS_PUT   = 5'd15;
  localparam step_t S_DEL       = 5'd16;
  localparam step_t S_DEL_ZERO  = 5'd17;
  localparam step_t S_DEL_INIT  = 5'd18;
  localparam step_t S_DEL_CHK   = 5'd19;
  localparam step_t S_DEL_GO    = 5'd20;
  localparam step_t S_RD        = 5'd21;
  localparam step_t S_RD_ADDR   = 5'd22;
  localparam step_t S_RD_TAKE   = 5'd23;
  localparam step_t S_BAD       = 5'd24;
  localparam step_t S_FULL      = 5'd25;
  localparam step_t S_PUSH      = 5'd26;

  // How the step counter moves.
  typedef enum logic [2:0] {
    JT_NEXT,   // step + 1
    JT_GOTO,   // unconditional jump
    JT_IF,     // jump when the condition holds, else step + 1
    JT_WAIT,   // hold until the condition holds, then jump
    JT_CMD     // jump to target + command code
  } jump_t;

  // Condition select for JT_IF and JT_WAIT.
  typedef enum logic [3:0] {
    C_NONE,
    C_IN_XFER,
    C_OUT_FREE,
    C_FULL,
    C_INS_BAD,
    C_DEL_BAD,
    C_NUM_ZERO,
    C_REM_ZERO,
    C_REM_MORE,
    C_IS_INS
  } cond_t;

  // Datapath action of one step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SET_BAD,
    OP_SET_FULL,
    OP_APPEND,
    OP_INS_INIT,
    OP_DEL_INIT,
    OP_PRIME,
    OP_MOVE,
    OP_INS_PUT,
    OP_DEL_DONE,
    OP_RD_ADDR,
    OP_RD_TAKE,
    OP_PUSH
  } dp_op_t;

  // One control word.
  typedef struct packed {
    jump_t  jt;
    cond_t  cs;
    step_t  target;
    dp_op_t op;
  } ctrl_t;

  // Status flags that the datapath reports to the sequencer.
  typedef struct packed {
    logic             in_xfer;
    logic             out_free;
    logic             full;
    logic             ins_bad;
    logic             del_bad;
    logic             num_zero;
    logic             rem_zero;
    logic             rem_more;
    logic             is_ins;
    logic [CMD_W-1:0] cmd;
  } dp_flags_t;

  // Control store. Element moves for insert and delete share one copy loop.
  function automatic ctrl_t ucode_rom(input step_t pc);
    ctrl_t w;
    w = '{jt: JT_NEXT, cs: C_NONE, target: S_IDLE, op: OP_NONE};
    case (pc)
      S_IDLE:     w = '{jt: JT_WAIT, cs: C_IN_XFER,  target: S_DISPATCH, op: OP_LATCH};
      S_DISPATCH: w = '{jt: JT_CMD,  cs: C_NONE,     target: S_JT,       op: OP_NONE};
      S_JT:       w = '{jt: JT_GOTO, cs: C_NONE,     target: S_APP,      op: OP_NONE};
      S_JT_INS:   w = '{jt: JT_GOTO, cs: C_NONE,     target: S_INS,      op: OP_NONE};
      S_JT_DEL:   w = '{jt: JT_GOTO, cs: C_NONE,     target: S_DEL,      op: OP_NONE};
      S_JT_RD:    w = '{jt: JT_GOTO, cs: C_NONE,     target: S_RD,       op: OP_NONE};
      S_APP:      w = '{jt: JT_IF,   cs: C_FULL,     target: S_FULL,     op: OP_NONE};
      S_APP_WR:   w = '{jt: JT_GOTO, cs: C_NONE,     target: S_PUSH,     op: OP_APPEND};
      S_INS:      w = '{jt: JT_IF,   cs: C_INS_BAD,  target: S_BAD,      op: OP_NONE};
      S_INS_FULL: w = '{jt: JT_IF,   cs: C_FULL,     target: S_FULL,     op: OP_NONE};
      S_INS_INIT: w = '{jt: JT_NEXT, cs: C_NONE,     target: S_IDLE,     op: OP_INS_INIT};
      S_MV_PRIME: w = '{jt: JT_NEXT, cs: C_NONE,     target: S_IDLE,     op: OP_PRIME};
      S_MV_LOOP:  w = '{jt: JT_IF,   cs: C_REM_MORE, target: S_MV_LOOP,  op: OP_MOVE};
      S_MV_END:   w = '{jt: JT_IF,   cs: C_IS_INS,   target: S_INS_PUT,  op: OP_NONE};
      S_DEL_FIN:  w = '{jt: JT_GOTO, cs: C_NONE,     target: S_PUSH,     op: OP_DEL_DONE};
      S_INS_PUT:  w = '{jt: JT_GOTO, cs: C_NONE,     target: S_PUSH,     op: OP_INS_PUT};
      S_DEL:      w = '{jt: JT_IF,   cs: C_DEL_BAD,  target: S_BAD,      op: OP_NONE};
      S_DEL_ZERO: w = '{jt: JT_IF,   cs: C_NUM_ZERO, target: S_PUSH,     op: OP_NONE};
      S_DEL_INIT: w = '{jt: JT_NEXT, cs: C_NONE,     target: S_IDLE,     op: OP_DEL_INIT};
      S_DEL_CHK:  w = '{jt: JT_IF,   cs: C_REM_ZERO, target: S_DEL_FIN,  op: OP_NONE};
      S_DEL_GO:   w = '{jt: JT_GOTO, cs: C_NONE,     target: S_MV_PRIME, op: OP_NONE};
      S_RD:       w = '{jt: JT_IF,   cs: C_INS_BAD,  target: S_BAD,      op: OP_NONE};
      S_RD_ADDR:  w = '{jt: JT_NEXT, cs: C_NONE,     target: S_IDLE,     op: OP_RD_ADDR};
      S_RD_TAKE:  w = '{jt: JT_GOTO, cs: C_NONE,     target: S_PUSH,     op: OP_RD_TAKE};
      S_BAD:      w = '{jt: JT_GOTO, cs: C_NONE,     target: S_PUSH,     op: OP_SET_BAD};
      S_FULL:     w = '{jt: JT_GOTO, cs: C_NONE,     target: S_PUSH,     op: OP_SET_FULL};
      S_PUSH:     w = '{jt: JT_WAIT, cs: C_OUT_FREE, target: S_IDLE,     op: OP_PUSH};
      default:    w = '{jt: JT_GOTO, cs: C_NONE,     target: S_IDLE,     op: OP_NONE};
    endcase
    return w;
  endfunction

endpackage

[src/plst_ifs.sv]
// Valid/ready channel interfaces for the positional list store.
// Depends on plst_pkg for the field widths.
`timescale 1ns / 1ps

interface plst_req_if import plst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [POS_W-1:0]        position;
  logic [NUM_W-1:0]        count;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, cmd, position, count, value, input ready);
  modport sink   (input valid, cmd, position, count, value, output ready);
endinterface

interface plst_rsp_if import plst_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STATUS_W-1:0]     status;
  logic signed [VAL_W-1:0] read_value;
  logic [LEN_W-1:0]        length;

  modport source (output valid, status, read_value, length, input ready);
  modport sink   (input valid, status, read_value, length, output ready);
endinterface

[src/plst_seq.sv]
// Microcode sequencer: step counter, control store lookup and jump logic.
// Depends on plst_pkg for the control word, flags and the control store.
`timescale 1ns / 1ps

module plst_seq import plst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  dp_flags_t flags,
  output ctrl_t     ctrl
);

  step_t pc;
  step_t pc_next;
  logic  cond;

  // Fetch the control word of the current step.
  assign ctrl = ucode_rom(pc);

  // Select the condition named by the control word.
  always_comb begin
    case (ctrl.cs)
      C_NONE:     cond = 1'b0;
      C_IN_XFER:  cond = flags.in_xfer;
      C_OUT_FREE: cond = flags.out_free;
      C_FULL:     cond = flags.full;
      C_INS_BAD:  cond = flags.ins_bad;
      C_DEL_BAD:  cond = flags.del_bad;
      C_NUM_ZERO: cond = flags.num_zero;
      C_REM_ZERO: cond = flags.rem_zero;
      C_REM_MORE: cond = flags.rem_more;
      C_IS_INS:   cond = flags.is_ins;
      default:    cond = 1'b0;
    endcase
  end

  // Next step address.
  always_comb begin
    case (ctrl.jt)
      JT_NEXT: pc_next = pc + step_t'(1);
      JT_GOTO: pc_next = ctrl.target;
      JT_IF:   pc_next = cond ? ctrl.target : pc + step_t'(1);
      JT_WAIT: pc_next = cond ? ctrl.target : pc;
      JT_CMD:  pc_next = ctrl.target + step_t'(flags.cmd);
      default: pc_next = S_IDLE;
    endcase
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // The counter only ever holds addresses of the program.
  a_pc_range: assert property (@(posedge clk) disable iff (rst) pc <= S_PUSH)
    else $error("step counter left the program");

  // A waiting step holds until its condition comes true.
  a_wait_hold: assert property (@(posedge clk) disable iff (rst)
      (ctrl.jt == JT_WAIT && !cond) |=> pc == $past(pc))
    else $error("wait step did not hold");

  // Leaving the idle step means a request transfer took place.
  a_idle_exit: assert property (@(posedge clk) disable iff (rst)
      (pc == S_IDLE && !flags.in_xfer) |=> pc == S_IDLE)
    else $error("idle step left without a request transfer");

endmodule

[src/plst_dp.sv]
// Datapath of the positional list store: element memory, count, copy pointers,
// request latch and response register. Driven one action per step.
// Depends on plst_pkg for codes, widths and the flag struct.
`timescale 1ns / 1ps

module plst_dp import plst_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_op_t                  op,
  output dp_flags_t               flags,
  input  logic                    req_valid,
  output logic                    req_ready,
  input  logic [CMD_W-1:0]        req_cmd,
  input  logic [POS_W-1:0]        req_position,
  input  logic [NUM_W-1:0]        req_count,
  input  logic signed [VAL_W-1:0] req_value,
  output logic                    rsp_valid,
  input  logic                    rsp_ready,
  output logic [STATUS_W-1:0]     rsp_status,
  output logic signed [VAL_W-1:0] rsp_read_value,
  output logic [LEN_W-1:0]        rsp_length
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = ((CW > POS_W) ? CW : POS_W) + 1;

  // Latched request.
  logic [CMD_W-1:0]    cmd_r;
  logic [POS_W-1:0]    pos_r;
  logic [NUM_W-1:0]    num_r;
  logic [VAL_W-1:0]    val_r;

  // Working registers.
  logic [CW-1:0]       count;
  logic [CW-1:0]       src;
  logic [CW-1:0]       dst;
  logic [CW-1:0]       rem;
  logic [STATUS_W-1:0] status_r;
  logic [VAL_W-1:0]    rd_r;

  // Element memory with a registered read port.
  logic [VAL_W-1:0]    mem [DEPTH];
  logic [VAL_W-1:0]    q;
  logic                we;
  logic [AW-1:0]       waddr;
  logic [VAL_W-1:0]    wdata;
  logic                re;
  logic [AW-1:0]       raddr;

  logic                in_xfer;
  logic                out_free;
  logic                dir_down;
  logic [SW-1:0]       pos_w;
  logic [SW-1:0]       cnt_w;
  logic [SW-1:0]       pos_m1;
  logic [SW-1:0]       gap_end;
  logic [CW-1:0]       src_next;
  logic [CW-1:0]       dst_next;

  // No request is taken while reset is held.
  assign req_ready = (op == OP_LATCH) && !rst;
  assign in_xfer   = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;
  assign dir_down  = (cmd_r == CMD_INSERT);

  // Position arithmetic, wide enough that no sum wraps for a nonzero position.
  assign pos_w   = SW'(pos_r);
  assign cnt_w   = SW'(count);
  assign pos_m1  = pos_w - SW'(1);
  assign gap_end = pos_m1 + SW'(num_r);

  // Insert copies toward the tail, delete toward the head.
  assign src_next = dir_down ? src - CW'(1) : src + CW'(1);
  assign dst_next = dir_down ? dst - CW'(1) : dst + CW'(1);

  // Flags for the sequencer.
  always_comb begin
    flags.in_xfer  = in_xfer;
    flags.out_free = out_free;
    flags.full     = (count >= CW'(DEPTH));
    flags.ins_bad  = (pos_r == '0) || (pos_w > cnt_w);
    flags.del_bad  = (pos_r == '0) || (pos_w > cnt_w) || (gap_end > cnt_w);
    flags.num_zero = (num_r == '0);
    flags.rem_zero = (rem == '0);
    flags.rem_more = (rem > CW'(1));
    flags.is_ins   = dir_down;
    flags.cmd      = cmd_r;
  end

  // Memory port decode.
  always_comb begin
    we    = 1'b0;
    waddr = count[AW-1:0];
    wdata = val_r;
    re    = 1'b0;
    raddr = src[AW-1:0];
    case (op)
      OP_APPEND: begin
        we = 1'b1;
      end
      OP_PRIME: begin
        re = 1'b1;
      end
      OP_MOVE: begin
        we    = 1'b1;
        waddr = dst[AW-1:0];
        wdata = q;
        re    = 1'b1;
      end
      OP_INS_PUT: begin
        we    = 1'b1;
        waddr = pos_m1[AW-1:0];
      end
      OP_RD_ADDR: begin
        re    = 1'b1;
        raddr = pos_m1[AW-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Memory array. Source and destination of one copy step never coincide.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q <= mem[raddr];
    end
  end

  // Element count and response valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      case (op)
        OP_APPEND:   count <= count + CW'(1);
        OP_INS_PUT:  count <= count + CW'(1);
        OP_DEL_DONE: count <= count - CW'(num_r);
        default:     count <= count;
      endcase
      if (op == OP_PUSH && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Request latch, copy pointers and result registers.
  always_ff @(posedge clk) begin
    case (op)
      OP_LATCH: begin
        if (in_xfer) begin
          cmd_r    <= req_cmd;
          pos_r    <= req_position;
          num_r    <= req_count;
          val_r    <= req_value;
          status_r <= ST_OK;
          rd_r     <= '0;
        end
      end
      OP_SET_BAD:  status_r <= ST_BAD;
      OP_SET_FULL: status_r <= ST_FULL;
      OP_INS_INIT: begin
        src <= count - CW'(1);
        dst <= count;
        rem <= CW'(cnt_w - pos_m1);
      end
      OP_DEL_INIT: begin
        src <= CW'(gap_end);
        dst <= CW'(pos_m1);
        rem <= CW'(cnt_w - gap_end);
      end
      OP_PRIME: src <= src_next;
      OP_MOVE: begin
        src <= src_next;
        dst <= dst_next;
        rem <= rem - CW'(1);
      end
      OP_RD_TAKE: rd_r <= q;
      OP_PUSH: begin
        if (out_free) begin
          rsp_status     <= status_r;
          rsp_read_value <= rd_r;
          rsp_length     <= LEN_W'(count);
        end
      end
      default: begin
        rd_r <= rd_r;
      end
    endcase
  end

  // The store never holds more than its capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("element count above capacity");

  // A copy step always has an element left to move.
  a_move_rem: assert property (@(posedge clk) disable iff (rst)
      op == OP_MOVE |-> rem != '0)
    else $error("copy step with nothing left to move");

  // The count changes only through append, insert or delete completion.
  a_count_src: assert property (@(posedge clk) disable iff (rst)
      (!$past(rst) && count != $past(count)) |->
      ($past(op) == OP_APPEND || $past(op) == OP_INS_PUT || $past(op) == OP_DEL_DONE))
    else $error("element count changed outside an update step");

endmodule

[src/positional_list_store_top.sv]
// Top level of the positional list store: request and response channels,
// microcode sequencer and datapath.
// Depends on plst_pkg, plst_ifs, plst_seq and plst_dp.
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit values, driven by a small
// microprogram. One request is taken at a time; its response is held in an
// output register, so the next request is taken while that response still
// waits, and a held response only delays the following response. Insert
// and delete shift elements through a copy loop, since the element memory
// has one write and one read port and the loop moves one element per cycle.
// An insert moves every element at or behind the insert position, a delete
// every element behind the removed run; when nothing trails the run, or
// zero elements are deleted, the loop is skipped. At most DEPTH - 1
// elements move, so the worst case is a delete at the head of a full store.
// The memory needs no clearing after reset.
module positional_list_store_top import plst_pkg::*; #(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic        clk,
  input logic        rst,
  plst_req_if.sink   req,
  plst_rsp_if.source rsp
);

  ctrl_t     ctrl;
  dp_flags_t flags;

  // Sequencer.
  plst_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // Datapath.
  plst_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (ctrl.op),
    .flags          (flags),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .req_cmd        (req.cmd),
    .req_position   (req.position),
    .req_count      (req.count),
    .req_value      (req.value),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.status),
    .rsp_read_value (rsp.read_value),
    .rsp_length     (rsp.length)
  );

endmodule
